// ===== rtl/core/erm_pkg.sv =====
package erm_pkg;

    localparam int NUM_PORTS = 64;
    localparam int PORT_W    = 6;
    localparam int TIME_W    = 48;
    localparam int CNT_W     = 64;
    localparam int RATE_W    = 56;
    localparam int FRAC_BITS = 16;
    localparam int NUM_LANES = 4;

    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam int INTV_W     = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd11796;
    localparam logic [INTV_W-1:0]  INTV_RESET  = 32'd3000000;

    localparam int                US_W     = 20;
    localparam logic [US_W-1:0]   US_PER_S = 20'd1000000;
    localparam int                HALF_W   = CNT_W / 2;
    localparam int                PP_W     = HALF_W + US_W;
    localparam int                PROD_W   = CNT_W + US_W;
    localparam int                NUM_W    = PROD_W + FRAC_BITS;
    localparam int                TOP_W    = NUM_W - RATE_W;

    localparam int BL_HALF = RATE_W / 2;
    localparam int BP_W    = ALPHA_W + BL_HALF;
    localparam int BS_W    = ALPHA_W + RATE_W;

    localparam int                DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'(RATE_W - 1);

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    localparam logic [1:0] ST_DEFER = 2'd0;
    localparam logic [1:0] ST_BASE  = 2'd1;
    localparam logic [1:0] ST_RATES = 2'd2;
    localparam logic [1:0] ST_RESET = 2'd3;

    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_INTV  = 1'b1;

    typedef struct packed {
        logic       capture;
        logic       sum_pk;
        logic       eval;
        logic       mul;
        logic       add;
        logic       div_init;
        logic       div_step;
        logic       bl1;
        logic       bl2;
        logic       bl3;
        logic       wr_base;
        logic       wr_rates;
        logic       clr_valid;
        logic       load_out;
        logic [1:0] st;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic has_base;
        logic zero_oct;
    } sts_t;

    typedef struct packed {
        logic                                active;
        logic [TIME_W-1:0]                   time_us;
        logic [NUM_LANES-1:0][CNT_W-1:0]     cnt;
        logic [NUM_LANES-1:0][RATE_W-1:0]    rate;
    } entry_t;

endpackage

// ===== rtl/core/erm_lane.sv =====
module erm_lane (
    input  logic                          clk,
    input  erm_pkg::cmd_t                 cmd,
    input  logic [erm_pkg::CNT_W-1:0]     cur,
    input  logic [erm_pkg::CNT_W-1:0]     last,
    input  logic [erm_pkg::TIME_W-1:0]    dt,
    input  logic [erm_pkg::ALPHA_W-1:0]   alpha,
    input  logic                          blend_en,
    input  logic [erm_pkg::RATE_W-1:0]    old,
    output logic [erm_pkg::RATE_W-1:0]    rate
);
    import erm_pkg::*;

    logic                neg_reg;
    logic [CNT_W-1:0]    delta_reg;
    logic [PP_W-1:0]     plo_reg;
    logic [PP_W-1:0]     phi_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [TIME_W-1:0]   rem_reg;
    logic [RATE_W-1:0]   numlo_reg;
    logic [RATE_W-1:0]   q_reg;
    logic                sat_reg;
    logic [BP_W-1:0]     pa_lo_reg;
    logic [BP_W-1:0]     pa_hi_reg;
    logic [BP_W-1:0]     pb_lo_reg;
    logic [BP_W-1:0]     pb_hi_reg;
    logic [BS_W-1:0]     sa_reg;
    logic [BS_W-1:0]     sb_reg;
    logic [RATE_W-1:0]   rate_reg;

    logic [NUM_W-1:0]    num;
    logic [TIME_W:0]     rem2;
    logic [TIME_W:0]     diff;
    logic                ge;
    logic [RATE_W-1:0]   raw;
    logic [ALPHA_W-1:0]  beta;
    logic [BS_W:0]       sum;

    always_comb
    begin
        num  = {prod_reg, {FRAC_BITS{1'b0}}};
        rem2 = {rem_reg, numlo_reg[RATE_W-1]};
        diff = rem2 - {1'b0, dt};
        ge   = (rem2 >= {1'b0, dt});
        raw  = neg_reg ? '0 : (sat_reg ? RATE_MAX : q_reg);
        beta = ALPHA_ONE - alpha;
        // round half up before dropping the alpha fraction
        sum  = {1'b0, sa_reg} + {1'b0, sb_reg} + (BS_W+1)'(1 << (ALPHA_FRAC - 1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            neg_reg   <= (cur < last);
            delta_reg <= cur - last;
        end
        if (cmd.mul)
        begin
            plo_reg <= delta_reg[HALF_W-1:0] * US_PER_S;
            phi_reg <= delta_reg[CNT_W-1:HALF_W] * US_PER_S;
        end
        if (cmd.add)
            prod_reg <= {phi_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, plo_reg};
        if (cmd.div_init)
        begin
            // quotient bits above the rate width only mean saturation
            rem_reg   <= TIME_W'(num[NUM_W-1:RATE_W]);
            sat_reg   <= ({{(TIME_W-TOP_W){1'b0}}, num[NUM_W-1:RATE_W]} >= dt);
            numlo_reg <= num[RATE_W-1:0];
            q_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg   <= ge ? diff[TIME_W-1:0] : rem2[TIME_W-1:0];
            numlo_reg <= {numlo_reg[RATE_W-2:0], 1'b0};
            q_reg     <= {q_reg[RATE_W-2:0], ge};
        end
        if (cmd.bl1)
        begin
            pa_lo_reg <= alpha * raw[BL_HALF-1:0];
            pa_hi_reg <= alpha * raw[RATE_W-1:BL_HALF];
            pb_lo_reg <= beta * old[BL_HALF-1:0];
            pb_hi_reg <= beta * old[RATE_W-1:BL_HALF];
        end
        if (cmd.bl2)
        begin
            sa_reg <= {pa_hi_reg, {BL_HALF{1'b0}}} + {{BL_HALF{1'b0}}, pa_lo_reg};
            sb_reg <= {pb_hi_reg, {BL_HALF{1'b0}}} + {{BL_HALF{1'b0}}, pb_lo_reg};
        end
        if (cmd.bl3)
            rate_reg <= blend_en ? sum[RATE_W+ALPHA_FRAC-1:ALPHA_FRAC] : raw;
    end

    assign rate = rate_reg;

endmodule

// ===== rtl/core/erm_datapath.sv =====
module erm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  erm_pkg::cmd_t                 cmd,
    output erm_pkg::sts_t                 sts,
    input  logic                          mode,
    input  logic [erm_pkg::PORT_W-1:0]    port,
    input  logic [erm_pkg::TIME_W-1:0]    now_us,
    input  logic [erm_pkg::CNT_W-1:0]     in_octets,
    input  logic [erm_pkg::CNT_W-1:0]     out_octets,
    input  logic [erm_pkg::CNT_W-1:0]     in_ucast,
    input  logic [erm_pkg::CNT_W-1:0]     in_nonucast,
    input  logic [erm_pkg::CNT_W-1:0]     out_ucast,
    input  logic [erm_pkg::CNT_W-1:0]     out_nonucast,
    input  logic [erm_pkg::ALPHA_W-1:0]   alpha_q16,
    input  logic [erm_pkg::INTV_W-1:0]    default_interval_us,
    output logic [erm_pkg::PORT_W-1:0]    port_out,
    output logic [1:0]                    status,
    output logic [erm_pkg::RATE_W-1:0]    rx_byte_rate,
    output logic [erm_pkg::RATE_W-1:0]    tx_byte_rate,
    output logic [erm_pkg::RATE_W-1:0]    rx_pkt_rate,
    output logic [erm_pkg::RATE_W-1:0]    tx_pkt_rate
);
    import erm_pkg::*;

    logic                 mode_reg;
    logic [PORT_W-1:0]    port_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [CNT_W-1:0]     in_oct_reg;
    logic [CNT_W-1:0]     out_oct_reg;
    logic [CNT_W-1:0]     in_uc_reg;
    logic [CNT_W-1:0]     in_nuc_reg;
    logic [CNT_W-1:0]     out_uc_reg;
    logic [CNT_W-1:0]     out_nuc_reg;
    logic [CNT_W-1:0]     rx_pk_reg;
    logic [CNT_W-1:0]     tx_pk_reg;
    logic [TIME_W-1:0]    dt_reg;
    logic [NUM_PORTS-1:0] valid_reg;
    entry_t               rd_reg;
    entry_t               wr_word;
    entry_t               mem [NUM_PORTS];

    logic [PORT_W-1:0]    port_out_reg;
    logic [1:0]           status_reg;
    logic [NUM_LANES-1:0][RATE_W-1:0] out_rate_reg;

    logic [NUM_LANES-1:0][CNT_W-1:0]  cur_cnt;
    logic [NUM_LANES-1:0][RATE_W-1:0] lane_rate;
    logic [ALPHA_W-1:0]   alpha_eff;
    logic [TIME_W-1:0]    dt_next;
    logic                 mem_wr;

    always_comb
    begin
        cur_cnt[0] = in_oct_reg;
        cur_cnt[1] = out_oct_reg;
        cur_cnt[2] = rx_pk_reg;
        cur_cnt[3] = tx_pk_reg;
        alpha_eff  = (alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : alpha_q16;
        if (now_reg > rd_reg.time_us)
            dt_next = now_reg - rd_reg.time_us;
        else if (default_interval_us == '0)
            dt_next = TIME_W'(1);
        else
            dt_next = TIME_W'(default_interval_us);
        wr_word.active  = cmd.wr_rates;
        wr_word.time_us = now_reg;
        wr_word.cnt     = cur_cnt;
        wr_word.rate    = lane_rate;
        mem_wr          = cmd.wr_base | cmd.wr_rates;
        sts.mode        = mode_reg;
        sts.has_base    = valid_reg[port_reg];
        sts.zero_oct    = (in_oct_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg    <= mode;
            port_reg    <= port;
            now_reg     <= now_us;
            in_oct_reg  <= in_octets;
            out_oct_reg <= out_octets;
            in_uc_reg   <= in_ucast;
            in_nuc_reg  <= in_nonucast;
            out_uc_reg  <= out_ucast;
            out_nuc_reg <= out_nonucast;
        end
        if (cmd.sum_pk)
        begin
            rx_pk_reg <= in_uc_reg + in_nuc_reg;
            tx_pk_reg <= out_uc_reg + out_nuc_reg;
        end
        if (cmd.eval)
            dt_reg <= dt_next;
        if (cmd.load_out)
        begin
            port_out_reg <= port_reg;
            status_reg   <= cmd.st;
            out_rate_reg <= (cmd.st == ST_RATES) ? lane_rate : '0;
        end
    end

    // per-port state word, read in the cycle after the port is captured
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[port_reg];
        if (mem_wr)
            mem[port_reg] <= wr_word;
    end

    // a port with its bit clear has no baseline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.clr_valid)
            valid_reg[port_reg] <= 1'b0;
        else if (cmd.wr_base)
            valid_reg[port_reg] <= 1'b1;
    end

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        erm_lane u_lane (
            .clk      (clk),
            .cmd      (cmd),
            .cur      (cur_cnt[k]),
            .last     (rd_reg.cnt[k]),
            .dt       (dt_reg),
            .alpha    (alpha_eff),
            .blend_en (rd_reg.active),
            .old      (rd_reg.rate[k]),
            .rate     (lane_rate[k])
        );
    end

    assign port_out     = port_out_reg;
    assign status       = status_reg;
    assign rx_byte_rate = out_rate_reg[0];
    assign tx_byte_rate = out_rate_reg[1];
    assign rx_pkt_rate  = out_rate_reg[2];
    assign tx_pkt_rate  = out_rate_reg[3];

endmodule

// ===== rtl/core/erm_ctrl.sv =====
module erm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  erm_pkg::sts_t sts,
    output erm_pkg::cmd_t cmd
);
    import erm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_ADD   = 4'd4;
    localparam logic [3:0] S_DINIT = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_BL1   = 4'd7;
    localparam logic [3:0] S_BL2   = 4'd8;
    localparam logic [3:0] S_BL3   = 4'd9;
    localparam logic [3:0] S_WB    = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]           st_reg, st_next;
    logic                 out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.st         = st_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.sum_pk = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                priority if (sts.mode)
                begin
                    cmd.clr_valid = 1'b1;
                    st_next       = ST_RESET;
                    state_next    = S_FIN;
                end
                else if (!sts.has_base)
                begin
                    if (sts.zero_oct)
                        st_next = ST_DEFER;
                    else
                    begin
                        cmd.wr_base = 1'b1;
                        st_next     = ST_BASE;
                    end
                    state_next = S_FIN;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_BL1;
            end
            S_BL1:
            begin
                cmd.bl1    = 1'b1;
                state_next = S_BL2;
            end
            S_BL2:
            begin
                cmd.bl2    = 1'b1;
                state_next = S_BL3;
            end
            S_BL3:
            begin
                cmd.bl3    = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.wr_base  = 1'b1;
                cmd.wr_rates = 1'b1;
                st_next      = ST_RATES;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                // hold here until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            st_reg        <= ST_DEFER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_READ))
        else $error("transfer in not followed by state read");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == DIV_LAST) |=> (state_reg == S_BL1))
        else $error("division did not end after its last step");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && (!out_valid_reg || out_ready))
        |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result not presented");
`endif

endmodule

// ===== rtl/core/port_counter_ewma_rate_meter.sv =====
// rate samples: read, eval, multiply, add, divide init, the 56 steps of a restoring divider,
// then the blend steps and write-back, run in four parallel rate lanes
// port reset, baseline and deferred samples: read and eval only, then the result is loaded
// a new item is taken once the last result is in the output register, also while it still waits there
// reset clears the per-port baseline bits, the handshake state and the configuration registers to
// their defaults; the per-port counter memory is not cleared and needs no clearing pass
module port_counter_ewma_rate_meter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [erm_pkg::PORT_W-1:0]    port,
    input  logic [erm_pkg::TIME_W-1:0]    now_us,
    input  logic [erm_pkg::CNT_W-1:0]     in_octets,
    input  logic [erm_pkg::CNT_W-1:0]     out_octets,
    input  logic [erm_pkg::CNT_W-1:0]     in_ucast,
    input  logic [erm_pkg::CNT_W-1:0]     in_nonucast,
    input  logic [erm_pkg::CNT_W-1:0]     out_ucast,
    input  logic [erm_pkg::CNT_W-1:0]     out_nonucast,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [erm_pkg::PORT_W-1:0]    port_out,
    output logic [1:0]                    status,
    output logic [erm_pkg::RATE_W-1:0]    rx_byte_rate,
    output logic [erm_pkg::RATE_W-1:0]    tx_byte_rate,
    output logic [erm_pkg::RATE_W-1:0]    rx_pkt_rate,
    output logic [erm_pkg::RATE_W-1:0]    tx_pkt_rate
);
    import erm_pkg::*;

    logic [ALPHA_W-1:0] alpha_reg;
    logic [INTV_W-1:0]  intv_reg;
    logic               cfg_wr;
    cmd_t               cmd;
    sts_t               sts;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            intv_reg  <= INTV_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ALPHA: alpha_reg <= pwdata[ALPHA_W-1:0];
                REG_INTV:  intv_reg  <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ALPHA: prdata = {{(32-ALPHA_W){1'b0}}, alpha_reg};
            REG_INTV:  prdata = intv_reg;
            default:   prdata = '0;
        endcase
    end

    erm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    erm_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .mode                (mode),
        .port                (port),
        .now_us              (now_us),
        .in_octets           (in_octets),
        .out_octets          (out_octets),
        .in_ucast            (in_ucast),
        .in_nonucast         (in_nonucast),
        .out_ucast           (out_ucast),
        .out_nonucast        (out_nonucast),
        .alpha_q16           (alpha_reg),
        .default_interval_us (intv_reg),
        .port_out            (port_out),
        .status              (status),
        .rx_byte_rate        (rx_byte_rate),
        .tx_byte_rate        (tx_byte_rate),
        .rx_pkt_rate         (rx_pkt_rate),
        .tx_pkt_rate         (tx_pkt_rate)
    );

endmodule
